// ===== hw/rtl/tlvd_pkg.sv =====
// tlvd_pkg: types, codes and the type-byte decoder shared by the tlv deframer
// no dependencies; compile first
package tlvd_pkg;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // frame type codes
  localparam logic [2:0] TYPE_F = 3'd0;
  localparam logic [2:0] TYPE_O = 3'd1;
  localparam logic [2:0] TYPE_L = 3'd2;
  localparam logic [2:0] TYPE_D = 3'd3;
  localparam logic [2:0] TYPE_E = 3'd4;

  // ascii type bytes
  localparam logic [7:0] BYTE_F = 8'h46;
  localparam logic [7:0] BYTE_O = 8'h4f;
  localparam logic [7:0] BYTE_L = 8'h4c;
  localparam logic [7:0] BYTE_D = 8'h44;
  localparam logic [7:0] BYTE_E = 8'h45;

  // deframer phase, one-hot
  typedef enum logic [6:0] {
    PH_TYPE    = 7'b0000001,
    PH_LEN1    = 7'b0000010,
    PH_LEN2    = 7'b0000100,
    PH_LEN3    = 7'b0001000,
    PH_LEN4    = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_HALTED  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] frame_type;
    logic [7:0] payload_byte;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } res_t;

  typedef struct packed {
    logic       known;
    logic [2:0] code;
  } type_dec_t;

  function automatic type_dec_t decode_type(logic [7:0] b);
    type_dec_t d;
    d.known = 1'b1;
    d.code  = TYPE_F;
    case (b)
      BYTE_F:  d.code = TYPE_F;
      BYTE_O:  d.code = TYPE_O;
      BYTE_L:  d.code = TYPE_L;
      BYTE_D:  d.code = TYPE_D;
      BYTE_E:  d.code = TYPE_E;
      default: d.known = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/tlvd_ifs.sv =====
// tlvd channel interfaces: byte input channel and result channel
// depends on nothing; compile after tlvd_pkg
interface tlvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tlvd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] frame_type;
  logic [7:0] payload_byte;
  logic       frame_end;
  modport source (output valid, output kind, output frame_type, output payload_byte,
                  output frame_end, input ready);
  modport sink   (input valid, input kind, input frame_type, input payload_byte,
                  input frame_end, output ready);
endinterface

// ===== hw/rtl/tlvd_core.sv =====
// tlvd_core: phase, frame type and byte count; computes the result of one byte
// depends on tlvd_pkg
module tlvd_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     data_byte,
  output tlvd_pkg::res_t res
);

  tlvd_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]       type_r, type_nxt;
  logic [31:0]      left_r, left_nxt;
  tlvd_pkg::type_dec_t dec;
  logic [31:0]      len_shift;
  logic [31:0]      left_dec;

  assign dec       = tlvd_pkg::decode_type(data_byte);
  assign len_shift = {left_r[23:0], data_byte};
  assign left_dec  = left_r - 32'd1;

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    left_nxt  = left_r;
    res.valid = 1'b0;
    res.data.kind         = tlvd_pkg::KIND_PAYLOAD;
    res.data.frame_type   = type_r;
    res.data.payload_byte = data_byte;
    res.data.frame_end    = 1'b0;
    case (phase_r)
      tlvd_pkg::PH_TYPE: begin
        if (dec.known) begin
          type_nxt  = dec.code;
          left_nxt  = 32'd0;
          phase_nxt = tlvd_pkg::PH_LEN1;
        end else begin
          res.valid           = 1'b1;
          res.data.kind       = tlvd_pkg::KIND_ERROR;
          res.data.frame_type = tlvd_pkg::TYPE_F;
          phase_nxt           = tlvd_pkg::PH_HALTED;
        end
      end
      tlvd_pkg::PH_LEN1: begin
        left_nxt  = len_shift;
        phase_nxt = tlvd_pkg::PH_LEN2;
      end
      tlvd_pkg::PH_LEN2: begin
        left_nxt  = len_shift;
        phase_nxt = tlvd_pkg::PH_LEN3;
      end
      tlvd_pkg::PH_LEN3: begin
        left_nxt  = len_shift;
        phase_nxt = tlvd_pkg::PH_LEN4;
      end
      tlvd_pkg::PH_LEN4: begin
        left_nxt = len_shift;
        if (len_shift == 32'd0) begin
          res.valid             = 1'b1;
          res.data.kind         = tlvd_pkg::KIND_EMPTY;
          res.data.payload_byte = 8'd0;
          res.data.frame_end    = 1'b1;
          phase_nxt             = tlvd_pkg::PH_TYPE;
        end else begin
          phase_nxt = tlvd_pkg::PH_PAYLOAD;
        end
      end
      tlvd_pkg::PH_PAYLOAD: begin
        left_nxt           = left_dec;
        res.valid          = 1'b1;
        res.data.frame_end = (left_dec == 32'd0);
        if (left_dec == 32'd0) begin
          phase_nxt = tlvd_pkg::PH_TYPE;
        end
      end
      default: begin
        // halted: swallow everything until reset
        phase_nxt = tlvd_pkg::PH_HALTED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tlvd_pkg::PH_TYPE;
      type_r  <= tlvd_pkg::TYPE_F;
      left_r  <= 32'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      left_r  <= left_nxt;
    end
  end

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.valid && res.data.kind == tlvd_pkg::KIND_ERROR |=> phase_r == tlvd_pkg::PH_HALTED)
    else $error("error result did not halt the deframer");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == tlvd_pkg::PH_HALTED |-> !res.valid)
    else $error("result produced while halted");

  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == tlvd_pkg::PH_PAYLOAD && left_r == 32'd1 |=> phase_r == tlvd_pkg::PH_TYPE)
    else $error("last payload byte did not return to type phase");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == tlvd_pkg::PH_PAYLOAD |-> left_r != 32'd0)
    else $error("payload phase with zero bytes left");

endmodule

// ===== hw/rtl/tlvd_out_reg.sv =====
// tlvd_out_reg: result register driving the result channel
// depends on tlvd_pkg and tlvd_ifs
module tlvd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  tlvd_pkg::result_t din,
  output logic              free,
  tlvd_out_if.source        out_ch
);

  logic              valid_r;
  tlvd_pkg::result_t data_r;

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.kind         = data_r.kind;
  assign out_ch.frame_type   = data_r.frame_type;
  assign out_ch.payload_byte = data_r.payload_byte;
  assign out_ch.frame_end    = data_r.frame_end;

endmodule

// ===== hw/rtl/tlv_frame_deframer.sv =====
// tlv_frame_deframer: byte-stream type/length/value deframer, top level
// depends on tlvd_pkg, tlvd_ifs, tlvd_core and tlvd_out_reg
//
// usage
//   in_ch carries one raw stream byte per request (valid/ready); out_ch carries
//   one result per payload byte, one per empty frame and one for an unknown
//   type byte. header bytes (type and four big-endian length bytes) give none.
//   after an unknown type byte the block swallows all input until reset.
// throughput
//   one byte per cycle sustained while out_ch takes results; the work per byte
//   is a type decode or length byte shift, a phase update and a 32-bit count
//   decrement and compare between the input register and the result register.
// result path
//   a byte lands in the input register at its accepting edge; its result is
//   loaded into the result register when the byte leaves the input register,
//   which a result on out_ch that is not yet taken can hold back, and from
//   there it is presented on out_ch.
// reset
//   rst_n low for one edge empties both registers and returns the phase to
//   awaiting a type byte with the count and type cleared.
// stall
//   while out_ch holds a result that is not taken, a byte that needs a result
//   waits in the input register and in_ch.ready drops; header and ignored
//   bytes keep flowing since they need no result slot.
module tlv_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  tlvd_in_if.sink    in_ch,
  tlvd_out_if.source out_ch
);

  // input register
  logic       in_v_r;
  logic [7:0] in_byte_r;

  tlvd_pkg::res_t res;
  logic           out_free;
  logic           adv;

  // byte leaves the input register when it needs no result or the slot frees
  assign adv         = in_v_r && (!res.valid || out_free);
  assign in_ch.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.data_byte;
    end
  end

  // phase / count state and per-byte result
  tlvd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .data_byte (in_byte_r),
    .res       (res)
  );

  // result register
  tlvd_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (adv && res.valid),
    .din    (res.data),
    .free   (out_free),
    .out_ch (out_ch)
  );

  a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r && $stable(in_byte_r))
    else $error("stalled input byte lost");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.valid |=> out_ch.valid)
    else $error("result not presented after advance");

endmodule

// ===== bench/tlv_frame_deframer_tb.sv =====
// tlv_frame_deframer_tb: self-checking bench for the type/length/value byte deframer
// depends on tlvd_pkg, tlvd_ifs and the tlv_frame_deframer rtl
// directed table, then random frame streams under changing idle patterns
`timescale 1ns / 1ps

module tlv_frame_deframer_tb;

  // cycles with no request moving on either side before we give up
  localparam int QUIET_LIMIT = 2000;
  // settle time after the last expected result (two-register pipeline)
  localparam int DRAIN_CYCLES = 20;

  // deframer state as the bench tracks it
  typedef struct packed {
    tlvd_pkg::phase_t ph;
    logic [2:0]       ftype;
    logic [31:0]      left;
  } deframer_state_t;

  // one row of the directed table: the byte, and optionally a hand-typed result
  typedef struct packed {
    logic [7:0]        data;
    logic              typed;
    tlvd_pkg::result_t res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  tlvd_in_if  in_ch ();
  tlvd_out_if out_ch ();

  tlv_frame_deframer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deframer_state_t   stream_st;          // state after every accepted byte
  tlvd_pkg::result_t pending_results[$]; // results still owed by the block, oldest first
  stim_row_t         stim_rows[$];
  logic [7:0]        frame_plan[$];      // bytes of the frame being generated
  int                src_idle_pct;
  int                sink_stall_pct;
  int                n_errors;
  int                n_results;
  int                quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // queue tails
  function automatic void owe_result(input tlvd_pkg::result_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic void plan_byte(input logic [7:0] b);
    frame_plan = {frame_plan, b};
  endfunction

  function automatic void queue_row(input stim_row_t row);
    stim_rows = {stim_rows, row};
  endfunction

  // advance the deframer by one byte; returns 1 when the byte yields a result
  function automatic logic deframe_step(inout deframer_state_t st, input logic [7:0] b,
                                        output tlvd_pkg::result_t r);
    logic       known;
    logic [2:0] code;
    r     = '0;
    known = 1'b1;
    code  = tlvd_pkg::TYPE_F;
    case (st.ph)
      tlvd_pkg::PH_TYPE: begin
        case (b)
          tlvd_pkg::BYTE_F: code = tlvd_pkg::TYPE_F;
          tlvd_pkg::BYTE_O: code = tlvd_pkg::TYPE_O;
          tlvd_pkg::BYTE_L: code = tlvd_pkg::TYPE_L;
          tlvd_pkg::BYTE_D: code = tlvd_pkg::TYPE_D;
          tlvd_pkg::BYTE_E: code = tlvd_pkg::TYPE_E;
          default:          known = 1'b0;
        endcase
        if (!known) begin
          // unknown type: report the byte itself, no frame completed, then halt
          r.kind         = tlvd_pkg::KIND_ERROR;
          r.frame_type   = tlvd_pkg::TYPE_F;
          r.payload_byte = b;
          r.frame_end    = 1'b0;
          st.ph          = tlvd_pkg::PH_HALTED;
          return 1'b1;
        end
        st.ftype = code;
        st.left  = '0;
        st.ph    = tlvd_pkg::PH_LEN1;
        return 1'b0;
      end
      tlvd_pkg::PH_LEN1: begin
        st.left = {st.left[23:0], b};
        st.ph   = tlvd_pkg::PH_LEN2;
        return 1'b0;
      end
      tlvd_pkg::PH_LEN2: begin
        st.left = {st.left[23:0], b};
        st.ph   = tlvd_pkg::PH_LEN3;
        return 1'b0;
      end
      tlvd_pkg::PH_LEN3: begin
        st.left = {st.left[23:0], b};
        st.ph   = tlvd_pkg::PH_LEN4;
        return 1'b0;
      end
      tlvd_pkg::PH_LEN4: begin
        // length is big-endian, last byte lands in the low bits
        st.left = {st.left[23:0], b};
        if (st.left == '0) begin
          r.kind         = tlvd_pkg::KIND_EMPTY;
          r.frame_type   = st.ftype;
          r.payload_byte = 8'h00;
          r.frame_end    = 1'b1;
          st.ph          = tlvd_pkg::PH_TYPE;
          return 1'b1;
        end
        st.ph = tlvd_pkg::PH_PAYLOAD;
        return 1'b0;
      end
      tlvd_pkg::PH_PAYLOAD: begin
        st.left        = st.left - 32'd1;
        r.kind         = tlvd_pkg::KIND_PAYLOAD;
        r.frame_type   = st.ftype;
        r.payload_byte = b;
        r.frame_end    = (st.left == '0);
        if (st.left == '0) st.ph = tlvd_pkg::PH_TYPE;
        return 1'b1;
      end
      default: begin
        // halted: swallow everything
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_type_byte();
    case ($urandom_range(4))
      0:       return tlvd_pkg::BYTE_F;
      1:       return tlvd_pkg::BYTE_O;
      2:       return tlvd_pkg::BYTE_L;
      3:       return tlvd_pkg::BYTE_D;
      default: return tlvd_pkg::BYTE_E;
    endcase
  endfunction

  // queue one frame: type, four length bytes, payload; now and then cut short
  function automatic void plan_frame();
    int unsigned len;
    int unsigned n_pay;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10)      len = 0;
    else if (pick < 60) len = $urandom_range(8, 1);
    else if (pick < 92) len = $urandom_range(64, 9);
    else                len = $urandom_range(300, 65);
    plan_byte(pick_type_byte());
    plan_byte(len[31:24]);
    plan_byte(len[23:16]);
    plan_byte(len[15:8]);
    plan_byte(len[7:0]);
    // broken frame: payload stops early and the next frame's bytes get absorbed
    n_pay = len;
    if (len > 1 && $urandom_range(99) < 4) n_pay = $urandom_range(len - 1);
    for (int i = 0; i < n_pay; i++) begin
      pick = $urandom_range(99);
      // sprinkle header-looking bytes into the payload
      if (pick < 15)      plan_byte(pick_type_byte());
      else if (pick < 25) plan_byte(8'h00);
      else                plan_byte(8'($urandom_range(255)));
    end
  endfunction

  // one byte request; entered just after a falling edge, returns at one
  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input tlvd_pkg::result_t typed_res);
    tlvd_pkg::result_t r;
    logic              has;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // accepted at this edge
    has = deframe_step(stream_st, b, r);
    if (has) owe_result(typed ? typed_res : r);
    @(negedge clk);
  endtask

  function automatic void add_row(input logic [7:0] b);
    stim_row_t row;
    row       = '0;
    row.data  = b;
    queue_row(row);
  endfunction

  function automatic void add_typed(input logic [7:0] b, input logic [1:0] kind,
                                    input logic [2:0] ftype, input logic [7:0] pbyte,
                                    input logic fend);
    stim_row_t row;
    row.data             = b;
    row.typed            = 1'b1;
    row.res.kind         = kind;
    row.res.frame_type   = ftype;
    row.res.payload_byte = pbyte;
    row.res.frame_end    = fend;
    queue_row(row);
  endfunction

  task automatic walk_rows();
    stim_row_t row;
    while (stim_rows.size() != 0) begin
      row = stim_rows.pop_front();
      send_byte(row.data, row.typed, row.res);
    end
  endtask

  // random well-formed frames (with the odd broken one); stops on a frame boundary
  task automatic run_frames(input int n_bytes);
    logic [7:0]        b;
    tlvd_pkg::result_t r;
    deframer_state_t   probe;
    int                sent;
    sent = 0;
    frame_plan.delete();
    while (sent < n_bytes || stream_st.ph != tlvd_pkg::PH_TYPE) begin
      // back at a type boundary: leftovers of an absorbed frame would read as
      // a random, possibly huge, length, so start a fresh frame instead
      if (stream_st.ph == tlvd_pkg::PH_TYPE) frame_plan.delete();
      if (frame_plan.size() == 0) plan_frame();
      b     = frame_plan.pop_front();
      probe = stream_st;
      // never let a random stream halt the block mid-run
      if (deframe_step(probe, b, r) && r.kind == tlvd_pkg::KIND_ERROR) begin
        frame_plan.delete();
      end else begin
        send_byte(b, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // result side: random stalls, changed only at the falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic flag_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("%s", msg);
  endtask

  // compare every result taken against the oldest one owed
  always @(posedge clk) begin
    tlvd_pkg::result_t got;
    tlvd_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind         = out_ch.kind;
      got.frame_type   = out_ch.frame_type;
      got.payload_byte = out_ch.payload_byte;
      got.frame_end    = out_ch.frame_end;
      n_results++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result %0d unexpected: kind %0d type %0d byte %02h end %0b",
                                n_results, got.kind, got.frame_type, got.payload_byte,
                                got.frame_end));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          flag_mismatch($sformatf({"result %0d: expected kind %0d type %0d byte %02h end %0b,",
                                   " got kind %0d type %0d byte %02h end %0b"},
                                  n_results, want.kind, want.frame_type, want.payload_byte,
                                  want.frame_end, got.kind, got.frame_type,
                                  got.payload_byte, got.frame_end));
      end
    end
  end

  // watchdog: nothing moving on either side for too long means a hang
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tlv_frame_deframer_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    n_errors        = 0;
    n_results       = 0;
    quiet_cycles    = 0;
    stream_st.ph    = tlvd_pkg::PH_TYPE;
    stream_st.ftype = tlvd_pkg::TYPE_F;
    stream_st.left  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: first frame straight out of reset is an empty type-E frame
    add_row(tlvd_pkg::BYTE_E); add_row(8'h00); add_row(8'h00); add_row(8'h00);
    add_typed(8'h00, tlvd_pkg::KIND_EMPTY, tlvd_pkg::TYPE_E, 8'h00, 1'b1);
    // single all-ones payload byte, which is also the frame's last
    add_row(tlvd_pkg::BYTE_D); add_row(8'h00); add_row(8'h00); add_row(8'h00);
    add_row(8'h01);
    add_typed(8'hff, tlvd_pkg::KIND_PAYLOAD, tlvd_pkg::TYPE_D, 8'hff, 1'b1);
    // two-byte payload: zero byte, then a byte that looks like a type byte
    add_row(tlvd_pkg::BYTE_O); add_row(8'h00); add_row(8'h00); add_row(8'h00);
    add_row(8'h02);
    add_row(8'h00); add_row(tlvd_pkg::BYTE_E);
    // empty frame right after a payload frame
    add_row(tlvd_pkg::BYTE_L); add_row(8'h00); add_row(8'h00); add_row(8'h00);
    add_typed(8'h00, tlvd_pkg::KIND_EMPTY, tlvd_pkg::TYPE_L, 8'h00, 1'b1);
    walk_rows();

    // random frames: no idling, sender gaps, result stalls, then both
    run_frames(300);
    src_idle_pct   = 59;
    run_frames(400);
    src_idle_pct   = 0;
    sink_stall_pct = 59;
    run_frames(400);
    src_idle_pct   = 24;
    sink_stall_pct = 24;
    run_frames(450);

    // closing: a clean frame, then an unknown type byte, after which the
    // block must swallow everything, including what would be a valid frame
    add_row(tlvd_pkg::BYTE_F); add_row(8'h00); add_row(8'h00); add_row(8'h00);
    add_row(8'h01);
    add_row(8'h80);
    add_typed(8'hff, tlvd_pkg::KIND_ERROR, tlvd_pkg::TYPE_F, 8'hff, 1'b0);
    add_row(tlvd_pkg::BYTE_D); add_row(8'h00); add_row(8'h00); add_row(8'h00);
    add_row(8'h00);
    add_row(tlvd_pkg::BYTE_F); add_row(8'h00); add_row(8'h00); add_row(8'h00);
    add_row(8'h01);
    for (int i = 0; i < 16; i++) add_row(8'($urandom_range(255)));
    walk_rows();
    in_ch.valid <= 1'b0;

    // drain what is still owed, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("tlv_frame_deframer_tb: done, clean");
    end else begin
      $display("tlv_frame_deframer_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== tlv_frame_deframer.f =====
hw/rtl/tlvd_pkg.sv
hw/rtl/tlvd_ifs.sv
hw/rtl/tlvd_core.sv
hw/rtl/tlvd_out_reg.sv
hw/rtl/tlv_frame_deframer.sv
bench/tlv_frame_deframer_tb.sv
